FILE: hw/rtl/postfix_stack_evaluator_core_assert.svh
// Assertion macros for the postfix stack evaluator.
// Both macros expect signals named clk and rst in the scope where they are used.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define PSE_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A trigger in one cycle that requires a consequence in the next cycle.
`define PSE_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// Used by the top level, the arithmetic unit and the checker; no dependencies.
package pse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int NUM_W       = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] MODE_NUMBER = 2'd0;
  localparam logic [1:0] MODE_BOOL   = 2'd1;
  localparam logic [1:0] MODE_OP     = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  typedef enum logic [3:0] {
    OP_NOT = 4'd0, OP_NEG = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
    OP_MUL = 4'd4, OP_DIV = 4'd5, OP_POW = 4'd6, OP_GT = 4'd7,
    OP_LT = 4'd8, OP_GE = 4'd9, OP_LE = 4'd10, OP_EQ = 4'd11,
    OP_NE = 4'd12, OP_AND = 4'd13, OP_OR = 4'd14
  } op_t;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_FEW       = 4'd1;
  localparam logic [3:0] ST_NOT_TYPE  = 4'd2;
  localparam logic [3:0] ST_NEG_TYPE  = 4'd3;
  localparam logic [3:0] ST_ARITH     = 4'd4;
  localparam logic [3:0] ST_DIV_ZERO  = 4'd5;
  localparam logic [3:0] ST_REL       = 4'd6;
  localparam logic [3:0] ST_EQ_MIX    = 4'd7;
  localparam logic [3:0] ST_LOGIC     = 4'd8;
  localparam logic [3:0] ST_EMPTY     = 4'd9;
  localparam logic [3:0] ST_LEFTOVER  = 4'd10;
  localparam logic [3:0] ST_OVERFLOW  = 4'd11;

  typedef enum logic [1:0] {
    AR_MUL = 2'd0,
    AR_DIV = 2'd1,
    AR_POW = 2'd2
  } arith_kind_t;

  typedef struct packed {
    logic        start;
    arith_kind_t kind;
  } arith_req_t;

  typedef struct packed {
    logic                  is_bool;
    logic [DATA_WIDTH-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic signed [31:0] number_value;
    logic              bool_value;
    logic [3:0]        operator_code;
  } token_t;

  typedef struct packed {
    logic [3:0]         status;
    logic               result_is_bool;
    logic signed [31:0] number_result;
    logic               bool_result;
  } result_t;

endpackage

FILE: hw/rtl/pse_arith.sv
// Multiply, iterative divide and iterative power unit for the postfix stack evaluator.
// Depends on pse_pkg.
module pse_arith (
  input  logic                           clk,
  input  logic                           rst,
  input  pse_pkg::arith_req_t            req,
  input  logic [pse_pkg::DATA_WIDTH-1:0] a,
  input  logic [pse_pkg::DATA_WIDTH-1:0] b,
  output logic                           done,
  output logic [pse_pkg::DATA_WIDTH-1:0] result
);
  import pse_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int IW = $clog2(DW + 1);

  typedef enum logic [4:0] {
    P_IDLE = 5'b00001,
    P_DIV  = 5'b00010,
    P_DFIX = 5'b00100,
    P_POW  = 5'b01000,
    P_FIN  = 5'b10000
  } phase_t;

  phase_t          phase;
  logic [DW-1:0]   acc;
  logic [DW-1:0]   base;
  logic [DW-1:0]   expo;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   quo;
  logic [DW-1:0]   dvs;
  logic            neg;
  logic [IW-1:0]   cnt;

  logic [DW-1:0]   mag_a;
  logic [DW-1:0]   mag_b;
  logic [DW:0]     shifted;
  logic [DW:0]     diff;

  assign mag_a   = a[DW-1] ? (DW'(0) - a) : a;
  assign mag_b   = b[DW-1] ? (DW'(0) - b) : b;
  assign shifted = {rem, quo[DW-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign done    = (phase == P_FIN);
  assign result  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      case (phase)
        P_IDLE: begin
          if (req.start) begin
            case (req.kind)
              AR_MUL: begin
                acc   <= a * b;
                phase <= P_FIN;
              end
              AR_DIV: begin
                quo   <= mag_a;
                dvs   <= mag_b;
                rem   <= '0;
                neg   <= a[DW-1] ^ b[DW-1];
                cnt   <= IW'(DW);
                phase <= P_DIV;
              end
              default: begin
                if (b[DW-1]) begin
                  if (a == DW'(1)) begin
                    acc <= DW'(1);
                  end else if (a == {DW{1'b1}}) begin
                    acc <= b[0] ? {DW{1'b1}} : DW'(1);
                  end else begin
                    acc <= '0;
                  end
                  phase <= P_FIN;
                end else begin
                  acc   <= DW'(1);
                  base  <= a;
                  expo  <= b;
                  phase <= P_POW;
                end
              end
            endcase
          end
        end
        P_DIV: begin
          if (!diff[DW]) begin
            rem <= diff[DW-1:0];
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= shifted[DW-1:0];
            quo <= {quo[DW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == IW'(1)) begin
            phase <= P_DFIX;
          end
        end
        P_DFIX: begin
          acc   <= neg ? (DW'(0) - quo) : quo;
          phase <= P_FIN;
        end
        P_POW: begin
          if (expo == '0) begin
            phase <= P_FIN;
          end else begin
            if (expo[0]) begin
              acc <= acc * base;
            end
            base <= base * base;
            expo <= expo >> 1;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/postfix_stack_evaluator_core.sv
// Top level of the postfix stack evaluator: token sequencer, stack memory, result register.
// Depends on pse_pkg and pse_arith.
//
//   channel  | direction | payload  | transaction
//   token    | in        | token_t  | token_valid && token_ready
//   result   | out       | result_t | result_valid && result_ready
//
// Pushes, end tokens and ignored tokens finish in S_IDLE; not and negate pass S_RD1 and S_EX;
// two-operand operators pass S_RD1, S_RD2 and S_EX, and multiply, divide and power then wait
// in S_WAIT on pse_arith, with its one-bit-per-cycle divider and square-and-multiply loop.
// The stack memory is read one entry per cycle through a registered read port.
// Reset clears the count, the latched error and the result valid flag; the stack needs no pass.
// An end token stalls while an earlier result is still waiting to be taken.
module postfix_stack_evaluator_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             token_valid,
  output logic             token_ready,
  input  pse_pkg::token_t  token,
  output logic             result_valid,
  input  logic             result_ready,
  output pse_pkg::result_t result
);
  import pse_pkg::*;

  localparam int DW = DATA_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD1  = 5'b00010,
    S_RD2  = 5'b00100,
    S_EX   = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [3:0]      err;
  logic [3:0]      err_next;
  op_t             op;
  entry_t          opnd_b;
  entry_t          bottom;
  entry_t          rd_q;
  logic [ADDR_W-1:0] raddr;
  logic            we;
  logic [ADDR_W-1:0] waddr;
  entry_t          wdata;
  arith_req_t      areq;
  logic            adone;
  logic [DW-1:0]   aresult;
  logic            accept;
  logic            end_blocked;
  op_t             tok_op;
  entry_t          opnd_a;
  logic            a_lt_b;
  logic            b_lt_a;
  result_t         result_next;

  entry_t mem [STACK_DEPTH];

  assign tok_op      = op_t'(token.operator_code);
  assign end_blocked = (token.mode == MODE_END) && result_valid && !result_ready;
  assign token_ready = (state == S_IDLE) && !end_blocked;
  assign accept      = token_valid && token_ready;
  assign opnd_a      = rd_q;
  assign a_lt_b      = $signed(opnd_a.value) < $signed(opnd_b.value);
  assign b_lt_a      = $signed(opnd_b.value) < $signed(opnd_a.value);
  assign raddr       = ADDR_W'(count - 1'b1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  pse_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (areq),
    .a      (opnd_a.value),
    .b      (opnd_b.value),
    .done   (adone),
    .result (aresult)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    err_next    = err;
    we          = 1'b0;
    waddr       = ADDR_W'(count);
    wdata       = '0;
    areq.start  = 1'b0;
    areq.kind   = AR_MUL;
    result_next = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (token.mode == MODE_END) begin
            if (err != ST_OK) begin
              result_next.status = err;
            end else if (count == '0) begin
              result_next.status = ST_EMPTY;
            end else if (count > CNT_W'(1)) begin
              result_next.status = ST_LEFTOVER;
            end else if (bottom.is_bool) begin
              result_next.result_is_bool = 1'b1;
              result_next.bool_result    = bottom.value[0];
            end else begin
              result_next.number_result = NUM_W'(bottom.value);
            end
            count_next = '0;
            err_next   = ST_OK;
          end else if (err == ST_OK) begin
            if (token.mode == MODE_NUMBER || token.mode == MODE_BOOL) begin
              if (count >= CNT_W'(STACK_DEPTH)) begin
                err_next = ST_OVERFLOW;
              end else begin
                we            = 1'b1;
                wdata.is_bool = (token.mode == MODE_BOOL);
                wdata.value   = (token.mode == MODE_BOOL) ? DW'(token.bool_value)
                                                          : DW'(token.number_value);
                count_next    = count + 1'b1;
              end
            end else if (token.operator_code inside {OP_NOT, OP_NEG}) begin
              if (count == '0) begin
                err_next = ST_FEW;
              end else begin
                state_next = S_RD1;
              end
            end else if (token.operator_code inside {[OP_ADD:OP_OR]}) begin
              if (count < CNT_W'(2)) begin
                err_next = ST_FEW;
              end else begin
                state_next = S_RD1;
              end
            end
          end
        end
      end
      S_RD1: begin
        count_next = count - 1'b1;
        state_next = (op == OP_NOT || op == OP_NEG) ? S_EX : S_RD2;
      end
      S_RD2: begin
        count_next = count - 1'b1;
        state_next = S_EX;
      end
      S_EX: begin
        state_next = S_IDLE;
        case (op)
          OP_NOT: begin
            if (!opnd_a.is_bool) begin
              err_next = ST_NOT_TYPE;
            end else begin
              we    = 1'b1;
              wdata = '{is_bool: 1'b1, value: opnd_a.value ^ DW'(1)};
            end
          end
          OP_NEG: begin
            if (opnd_a.is_bool) begin
              err_next = ST_NEG_TYPE;
            end else begin
              we    = 1'b1;
              wdata = '{is_bool: 1'b0, value: DW'(0) - opnd_a.value};
            end
          end
          OP_ADD, OP_SUB: begin
            if (opnd_a.is_bool || opnd_b.is_bool) begin
              err_next = ST_ARITH;
            end else begin
              we    = 1'b1;
              wdata = '{is_bool: 1'b0, value: (op == OP_ADD) ? opnd_a.value + opnd_b.value
                                                            : opnd_a.value - opnd_b.value};
            end
          end
          OP_MUL, OP_DIV, OP_POW: begin
            if (opnd_a.is_bool || opnd_b.is_bool) begin
              err_next = ST_ARITH;
            end else if (op == OP_DIV && opnd_b.value == '0) begin
              err_next = ST_DIV_ZERO;
            end else begin
              areq.start = 1'b1;
              areq.kind  = (op == OP_MUL) ? AR_MUL : ((op == OP_DIV) ? AR_DIV : AR_POW);
              state_next = S_WAIT;
            end
          end
          OP_GT, OP_LT, OP_GE, OP_LE: begin
            if (opnd_a.is_bool || opnd_b.is_bool) begin
              err_next = ST_REL;
            end else begin
              we            = 1'b1;
              wdata.is_bool = 1'b1;
              case (op)
                OP_GT:   wdata.value = DW'(b_lt_a);
                OP_LT:   wdata.value = DW'(a_lt_b);
                OP_GE:   wdata.value = DW'(!a_lt_b);
                default: wdata.value = DW'(!b_lt_a);
              endcase
            end
          end
          OP_EQ, OP_NE: begin
            if (opnd_a.is_bool != opnd_b.is_bool) begin
              err_next = ST_EQ_MIX;
            end else begin
              we    = 1'b1;
              wdata = '{is_bool: 1'b1,
                        value: DW'((opnd_a.value == opnd_b.value) ^ (op == OP_NE))};
            end
          end
          default: begin
            if (!opnd_a.is_bool || !opnd_b.is_bool) begin
              err_next = ST_LOGIC;
            end else begin
              we    = 1'b1;
              wdata = '{is_bool: 1'b1, value: (op == OP_AND) ? opnd_a.value & opnd_b.value
                                                            : opnd_a.value | opnd_b.value};
            end
          end
        endcase
        if (we) begin
          count_next = count + 1'b1;
        end
      end
      S_WAIT: begin
        if (adone) begin
          we         = 1'b1;
          wdata      = '{is_bool: 1'b0, value: aresult};
          count_next = count + 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
      if (accept && token.mode == MODE_END) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && token.mode == MODE_END) begin
      result <= result_next;
    end
    if (accept && token.mode == MODE_OP) begin
      op <= tok_op;
    end
    if (state == S_RD2) begin
      opnd_b <= rd_q;
    end
    if (we && waddr == '0) begin
      bottom <= wdata;
    end
  end

endmodule

FILE: hw/rtl/pse_checker.sv
// Port-level checks on the token and result channels of the postfix stack evaluator.
// Depends on pse_pkg and the assertion macro header; bound to the top level below.
`include "postfix_stack_evaluator_core_assert.svh"

module pse_checker (
  input logic             clk,
  input logic             rst,
  input logic             token_valid,
  input logic             token_ready,
  input pse_pkg::token_t  token,
  input logic             result_valid,
  input logic             result_ready,
  input pse_pkg::result_t result
);
  import pse_pkg::*;

  `PSE_ASSERT_NEXT(a_token_hold, token_valid && !token_ready, token_valid && $stable(token), "token dropped")
  `PSE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped")
  `PSE_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result), "result changed")
  `PSE_ASSERT_NOW(a_status_range, !result_valid || result.status <= ST_OVERFLOW, "bad status")
  `PSE_ASSERT_NOW(a_error_clean, !result_valid || result.status == ST_OK || (!result.result_is_bool && result.number_result == 0 && !result.bool_result), "error result not cleared")

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (
  .clk          (clk),
  .rst          (rst),
  .token_valid  (token_valid),
  .token_ready  (token_ready),
  .token        (token),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: sim/postfix_stack_evaluator_core_tb.sv
// Testbench for postfix_stack_evaluator_core: drives token streams and checks end-of-expression results.
// A scoreboard class predicts each result from its own copy of the stack; depends on pse_pkg.
module postfix_stack_evaluator_core_tb;
  import pse_pkg::*;

  class eval_scoreboard;
    logic [31:0] vals[64];
    logic        types[64];
    int          count;
    logic [3:0]  err;
    result_t     pending[$];
    int          fails;

    function new();
      count = 0;
      err = ST_OK;
      fails = 0;
    endfunction

    function void push_entry(logic [31:0] v, logic t);
      if (count >= 64) begin
        err = ST_OVERFLOW;
      end else begin
        vals[count] = v;
        types[count] = t;
        count++;
      end
    endfunction

    function logic [31:0] power(logic [31:0] b, logic [31:0] e);
      logic [31:0] r;
      r = 32'd1;
      if (e[31]) begin
        if (b == 32'd1) return 32'd1;
        if (b == 32'hFFFFFFFF) return e[0] ? 32'hFFFFFFFF : 32'd1;
        return 32'd0;
      end
      while (e != 0) begin
        if (e[0]) r = r * b;
        b = b * b;
        e = e >> 1;
      end
      return r;
    endfunction

    function void apply_op(logic [3:0] code);
      logic signed [31:0] a, b;
      logic [31:0] r;
      logic ta, tb, rt;
      rt = 1'b0;
      r = '0;
      if (code > 4'd14) return;
      if (code <= OP_NEG) begin
        if (count < 1) begin
          err = ST_FEW;
          return;
        end
        count--;
        a = vals[count];
        ta = types[count];
        if (code == OP_NOT) begin
          if (!ta) err = ST_NOT_TYPE;
          else push_entry(a ^ 32'd1, 1'b1);
        end else begin
          if (ta) err = ST_NEG_TYPE;
          else push_entry(-a, 1'b0);
        end
        return;
      end
      if (count < 2) begin
        err = ST_FEW;
        return;
      end
      count--;
      b = vals[count];
      tb = types[count];
      count--;
      a = vals[count];
      ta = types[count];
      if (code <= OP_POW) begin
        if (ta || tb) begin
          err = ST_ARITH;
          return;
        end
        case (code)
          OP_ADD: r = a + b;
          OP_SUB: r = a - b;
          OP_MUL: r = a * b;
          OP_DIV: begin
            if (b == 0) begin
              err = ST_DIV_ZERO;
              return;
            end
            if (a == 32'sh80000000 && b == -1) r = a;
            else r = a / b;
          end
          default: r = power(a, b);
        endcase
      end else if (code <= OP_LE) begin
        if (ta || tb) begin
          err = ST_REL;
          return;
        end
        rt = 1'b1;
        case (code)
          OP_GT: r = 32'(a > b);
          OP_LT: r = 32'(a < b);
          OP_GE: r = 32'(a >= b);
          default: r = 32'(a <= b);
        endcase
      end else if (code <= OP_NE) begin
        if (ta != tb) begin
          err = ST_EQ_MIX;
          return;
        end
        rt = 1'b1;
        r = 32'((a == b) ^ (code == OP_NE));
      end else begin
        if (!ta || !tb) begin
          err = ST_LOGIC;
          return;
        end
        rt = 1'b1;
        r = (code == OP_AND) ? (a & b) : (a | b);
      end
      push_entry(r, rt);
    endfunction

    function void note_token(token_t t);
      result_t res;
      if (t.mode != MODE_END) begin
        if (err != ST_OK) return;
        if (t.mode == MODE_NUMBER) push_entry(t.number_value, 1'b0);
        else if (t.mode == MODE_BOOL) push_entry({31'd0, t.bool_value}, 1'b1);
        else apply_op(t.operator_code);
        return;
      end
      res = '0;
      if (err != ST_OK) res.status = err;
      else if (count == 0) res.status = ST_EMPTY;
      else if (count > 1) res.status = ST_LEFTOVER;
      else if (types[0]) begin
        res.result_is_bool = 1'b1;
        res.bool_result = vals[0][0];
      end else res.number_result = vals[0];
      count = 0;
      err = ST_OK;
      pending.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fails++;
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        fails++;
      end
      if (got.result_is_bool != exp.result_is_bool) begin
        $display("%0t: result_is_bool expected %0d actual %0d", $time,
                 exp.result_is_bool, got.result_is_bool);
        fails++;
      end
      if (got.number_result != exp.number_result) begin
        $display("%0t: number_result expected %0d actual %0d", $time,
                 exp.number_result, got.number_result);
        fails++;
      end
      if (got.bool_result != exp.bool_result) begin
        $display("%0t: bool_result expected %0d actual %0d", $time,
                 exp.bool_result, got.bool_result);
        fails++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    token_valid = 1'b0;
  logic    token_ready;
  token_t  token = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  eval_scoreboard sb = new();
  bit      stim_done = 1'b0;
  bit      hold_off = 1'b0;
  int      cycles = 0;
  int      sent = 0;

  postfix_stack_evaluator_core u_top (
    .clk(clk), .rst(rst),
    .token_valid(token_valid), .token_ready(token_ready), .token(token),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (!rst && token_valid && token_ready) sb.note_token(token);
  end

  task automatic send_token(logic [1:0] m, logic [31:0] nv, logic bv, logic [3:0] oc);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      token_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    token_valid <= 1'b1;
    token <= '{mode: m, number_value: nv, bool_value: bv, operator_code: oc};
    @(posedge clk);
    while (!token_ready) @(posedge clk);
    sent++;
  endtask

  task automatic push_num(logic [31:0] v);
    send_token(MODE_NUMBER, v, 1'($urandom), 4'($urandom));
  endtask

  task automatic push_bool(logic v);
    send_token(MODE_BOOL, $urandom, v, 4'($urandom));
  endtask

  task automatic do_op(logic [3:0] oc);
    send_token(MODE_OP, $urandom, 1'($urandom), oc);
  endtask

  task automatic end_expr();
    send_token(MODE_END, $urandom, 1'($urandom), 4'($urandom));
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4);
      1: return -$urandom_range(1, 3);
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_expr();
    int depth;
    int steps;
    logic [3:0] oc;
    depth = 0;
    steps = $urandom_range(1, 8);
    repeat (steps) begin
      if ($urandom_range(0, 19) == 0) begin
        send_token(2'($urandom), $urandom, 1'($urandom), 4'($urandom));
      end else if (depth < 2 || $urandom_range(0, 1)) begin
        if ($urandom_range(0, 3) == 0) push_bool(1'($urandom));
        else push_num(rand_num());
        depth++;
      end else begin
        oc = 4'($urandom_range(0, 14));
        if (oc == OP_DIV || oc == OP_POW) begin
          if ($urandom_range(0, 2) != 0) oc = 4'(OP_ADD + $urandom_range(0, 2));
        end
        do_op(oc);
        depth = (oc <= OP_NEG) ? depth : depth - 1;
      end
    end
    end_expr();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    push_num(32'h7FFFFFFF); push_num(1); do_op(OP_ADD); end_expr();
    push_num(32'h80000000); push_num(-1); do_op(OP_DIV); end_expr();
    push_num(7); push_num(0); do_op(OP_DIV); end_expr();
    push_num(0); push_num(0); do_op(OP_POW); end_expr();
    push_num(-1); push_num(-3); do_op(OP_POW); end_expr();
    push_num(1); push_num(-5); do_op(OP_POW); end_expr();
    push_num(3); push_num(-2); do_op(OP_POW); end_expr();
    push_bool(1); do_op(OP_NOT); end_expr();
    push_bool(0); do_op(OP_NEG); end_expr();
    do_op(4'd15); end_expr();
    end_expr();
    push_num(1); push_bool(1); do_op(OP_EQ); push_num(5); end_expr();
    for (int i = 0; i < 15; i++) begin
      push_num(rand_num()); push_bool(1); do_op(4'(i)); end_expr();
      push_bool(0); push_bool(1); do_op(4'(i)); end_expr();
      push_num(rand_num()); push_num(rand_num()); do_op(4'(i)); end_expr();
    end
    hold_off = 1'b1;
    repeat (66) push_num($urandom);
    end_expr();
    push_num(1); end_expr();
    push_num(2); end_expr();
    hold_off = 1'b0;
    while (sent < 1850) rand_expr();
    token_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      if (hold_off && !held) begin
        gap = 600;
        held = 1'b1;
      end
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
